[sv/stx_pkg.sv]
// shared types, codes and character helpers for the s-expression tokenizer
package stx_pkg;

    // lexer modes
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_STRING  = 3'd2,
        MODE_CHAR    = 3'd3,
        MODE_ATOM    = 3'd4
    } t_mode;

    // result kinds
    typedef enum logic [3:0] {
        KIND_TEXT  = 4'd0,
        KIND_LPAR  = 4'd1,
        KIND_RPAR  = 4'd2,
        KIND_DOT   = 4'd3,
        KIND_QUOTE = 4'd4,
        KIND_NUM   = 4'd5,
        KIND_STR   = 4'd6,
        KIND_SYM   = 4'd7,
        KIND_CHAR  = 4'd8,
        KIND_EOF   = 4'd9,
        KIND_ERR   = 4'd10
    } t_kind;

    // error codes
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_UNTERM   = 2'd1,
        ERR_CHAR_EOF = 2'd2,
        ERR_TOO_LONG = 2'd3
    } t_err;

    // register indexes on the configuration port
    localparam logic REG_MAX_TOKEN_LEN = 1'b0;

    // special characters
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // one result beat
    typedef struct packed {
        t_kind      kind;
        logic [7:0] text_byte;
        t_err       error_code;
        logic       last;
    } t_result;

    // results of one lexer step, handed to the result queue
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic t_result mk_res(input t_kind k, input logic [7:0] b, input t_err e);
        t_result r;
        r.kind       = k;
        r.text_byte  = b;
        r.error_code = e;
        r.last       = 1'b0;
        mk_res = r;
    endfunction

endpackage

[sv/sexpr_tokenizer.sv]
// top level of the s-expression tokenizer: input register, config port, lexer, result queue

// Lexes one byte per cycle while the input side is not stalled. An accepted
// byte is held in the input register, is lexed in a single pass against the
// lexer state, and its zero, one or two results go into a four-beat result
// queue whose head drives the output port.
// A byte that causes two results (atom end then rpar or eof, error then eof,
// char body then char end) needs two output beats; the input side stalls
// only while the result queue holds more than two beats. max_token_len is
// taken at APB byte address 0; the user must write it only while the stream
// is idle, and the block does not enforce this. The limit in force is the smaller of it and TOKEN_BUFFER_BYTES - 1.
module sexpr_tokenizer import stx_pkg::*; #(
    parameter int TOKEN_BUFFER_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_ch_byte,
    input  logic        i_end_of_input,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_kind,
    output logic [7:0]  o_text_byte,
    output logic [1:0]  o_error_code,
    output logic        o_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int         LenCapInt = (TOKEN_BUFFER_BYTES - 1 < 255) ? TOKEN_BUFFER_BYTES - 1 : 255;
    localparam logic [7:0] LenCap    = 8'(LenCapInt);

    logic [7:0] r_max_token_len;
    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_eoi;
    logic [7:0] limit;
    logic       step;
    logic       room2;
    logic       q_valid;
    t_push      push;
    t_result    head;
    logic       cfg_wr;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_TOKEN_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_token_len <= 8'd255;
        end else if (cfg_wr) begin
            r_max_token_len <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_TOKEN_LEN) ? {24'h0, r_max_token_len} : 32'h0;
    assign limit  = (r_max_token_len < LenCap) ? r_max_token_len : LenCap;

    // input register
    assign step       = r_in_valid && room2;
    assign o_in_stall = r_in_valid && !room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_ch  <= i_ch_byte;
            r_eoi <= i_end_of_input;
        end
    end

    // lexer
    stx_lex u_lex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_ch    (r_ch),
        .i_eoi   (r_eoi),
        .i_limit (limit),
        .o_push  (push)
    );

    // result queue
    stx_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_out_stall),
        .o_valid (q_valid),
        .o_room2 (room2),
        .o_head  (head)
    );

    assign o_out_valid  = q_valid;
    assign o_kind       = head.kind;
    assign o_text_byte  = head.text_byte;
    assign o_error_code = head.error_code;
    assign o_last       = head.last;

endmodule

[sv/stx_lex.sv]
// lexer state and the single-pass step logic for one input byte
module stx_lex import stx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_ch,
    input  logic       i_eoi,
    input  logic [7:0] i_limit,
    output t_push      o_push
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_len, n_len;
    logic       r_after_bs, n_after_bs;
    logic       r_all_digits, n_all_digits;
    logic       r_first_sign, n_first_sign;

    t_result    res0, res1;
    logic [1:0] n_res;
    logic       too_long;
    t_kind      atom_kind;
    logic       sign;

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_len        <= '0;
            r_after_bs   <= 1'b0;
            r_all_digits <= 1'b1;
            r_first_sign <= 1'b0;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_len        <= n_len;
            r_after_bs   <= n_after_bs;
            r_all_digits <= n_all_digits;
            r_first_sign <= n_first_sign;
        end
    end

    // body length check and atom classification
    assign too_long  = (r_len >= i_limit);
    assign atom_kind = (r_all_digits && !(r_first_sign && r_len == 8'd1)) ? KIND_NUM : KIND_SYM;
    assign sign      = (i_ch == CH_PLUS) || (i_ch == CH_MINUS);

    // step: next state and up to two results
    always_comb begin
        n_mode       = r_mode;
        n_len        = r_len;
        n_after_bs   = r_after_bs;
        n_all_digits = r_all_digits;
        n_first_sign = r_first_sign;
        res0         = mk_res(KIND_EOF, 8'h00, ERR_NONE);
        res1         = mk_res(KIND_EOF, 8'h00, ERR_NONE);
        n_res        = 2'd0;

        if (i_eoi) begin
            n_mode = MODE_IDLE;
            case (r_mode)
                MODE_STRING: begin
                    res0  = mk_res(KIND_ERR, 8'h00, ERR_UNTERM);
                    n_res = 2'd2;
                end
                MODE_CHAR: begin
                    res0  = mk_res(KIND_ERR, 8'h00, ERR_CHAR_EOF);
                    n_res = 2'd2;
                end
                MODE_ATOM: begin
                    res0  = mk_res(atom_kind, 8'h00, ERR_NONE);
                    n_res = 2'd2;
                end
                default: begin
                    n_res = 2'd1;
                end
            endcase
            if (n_res == 2'd2) begin
                res1 = mk_res(KIND_EOF, 8'h00, ERR_NONE);
            end else begin
                res0 = mk_res(KIND_EOF, 8'h00, ERR_NONE);
            end
        end else begin
            case (r_mode)
                MODE_COMMENT: begin
                    if (i_ch == CH_LF) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_STRING: begin
                    if (i_ch == CH_DQUOTE && !r_after_bs) begin
                        res0   = mk_res(KIND_STR, 8'h00, ERR_NONE);
                        n_res  = 2'd1;
                        n_mode = MODE_IDLE;
                    end else if (too_long) begin
                        res0   = mk_res(KIND_ERR, 8'h00, ERR_TOO_LONG);
                        n_res  = 2'd1;
                        n_mode = MODE_IDLE;
                    end else begin
                        res0       = mk_res(KIND_TEXT, i_ch, ERR_NONE);
                        n_res      = 2'd1;
                        n_len      = r_len + 8'd1;
                        n_after_bs = (i_ch == CH_BSLASH) && !r_after_bs;
                    end
                end
                MODE_CHAR: begin
                    n_mode = MODE_IDLE;
                    if (too_long) begin
                        res0  = mk_res(KIND_ERR, 8'h00, ERR_TOO_LONG);
                        n_res = 2'd1;
                    end else begin
                        res0  = mk_res(KIND_TEXT, i_ch, ERR_NONE);
                        res1  = mk_res(KIND_CHAR, 8'h00, ERR_NONE);
                        n_res = 2'd2;
                        n_len = r_len + 8'd1;
                    end
                end
                MODE_ATOM: begin
                    if (is_ws(i_ch)) begin
                        res0   = mk_res(atom_kind, 8'h00, ERR_NONE);
                        n_res  = 2'd1;
                        n_mode = MODE_IDLE;
                    end else if (i_ch == CH_RPAR) begin
                        res0   = mk_res(atom_kind, 8'h00, ERR_NONE);
                        res1   = mk_res(KIND_RPAR, 8'h00, ERR_NONE);
                        n_res  = 2'd2;
                        n_mode = MODE_IDLE;
                    end else if (too_long) begin
                        res0   = mk_res(KIND_ERR, 8'h00, ERR_TOO_LONG);
                        n_res  = 2'd1;
                        n_mode = MODE_IDLE;
                    end else begin
                        res0         = mk_res(KIND_TEXT, i_ch, ERR_NONE);
                        n_res        = 2'd1;
                        n_len        = r_len + 8'd1;
                        n_all_digits = r_all_digits && is_digit(i_ch);
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                    if (is_ws(i_ch)) begin
                        n_mode = MODE_IDLE;
                    end else if (i_ch == CH_SEMI) begin
                        n_mode = MODE_COMMENT;
                    end else if (i_ch == CH_LPAR) begin
                        res0  = mk_res(KIND_LPAR, 8'h00, ERR_NONE);
                        n_res = 2'd1;
                    end else if (i_ch == CH_RPAR) begin
                        res0  = mk_res(KIND_RPAR, 8'h00, ERR_NONE);
                        n_res = 2'd1;
                    end else if (i_ch == CH_QUOTE) begin
                        res0  = mk_res(KIND_QUOTE, 8'h00, ERR_NONE);
                        n_res = 2'd1;
                    end else if (i_ch == CH_DOT) begin
                        res0  = mk_res(KIND_DOT, 8'h00, ERR_NONE);
                        n_res = 2'd1;
                    end else begin
                        // string, char literal or atom: fresh token
                        n_len        = '0;
                        n_after_bs   = 1'b0;
                        n_all_digits = 1'b1;
                        n_first_sign = 1'b0;
                        if (i_ch == CH_DQUOTE) begin
                            n_mode = MODE_STRING;
                        end else if (i_ch == CH_BSLASH) begin
                            n_mode = MODE_CHAR;
                        end else if (i_limit == 8'd0) begin
                            // first atom byte already over the limit
                            res0  = mk_res(KIND_ERR, 8'h00, ERR_TOO_LONG);
                            n_res = 2'd1;
                        end else begin
                            n_mode       = MODE_ATOM;
                            res0         = mk_res(KIND_TEXT, i_ch, ERR_NONE);
                            n_res        = 2'd1;
                            n_len        = 8'd1;
                            n_first_sign = sign;
                            n_all_digits = sign || is_digit(i_ch);
                        end
                    end
                end
            endcase
        end

        // mark the final result of the step
        res0.last = (n_res == 2'd1);
        res1.last = 1'b1;
    end

    assign o_push.count = i_step ? n_res : 2'd0;
    assign o_push.res0  = res0;
    assign o_push.res1  = res1;

    // end of input always leaves the lexer idle
    a_eoi_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_eoi |=> r_mode == MODE_IDLE)
        else $error("lexer not idle after end of input");

    // token body never grows past the limit in effect
    a_len_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_eoi && n_len > r_len |-> r_len < i_limit)
        else $error("token body grew past limit");

endmodule

[sv/stx_outq.sv]
// four-beat result queue between the lexer and the output channel
module stx_outq import stx_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_valid,
    output logic    o_room2,
    output t_result o_head
);

    localparam int Depth = 4;

    t_result    r_mem [Depth];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count, n_count;
    logic       pop;

    assign pop = i_pop && (r_count != 3'd0);

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr + i_push.count;
        n_rd_ptr = r_rd_ptr + {1'b0, pop};
        n_count  = r_count + {1'b0, i_push.count} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry writes, up to two per cycle
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_push.res1;
        end
    end

    assign o_valid = (r_count != 3'd0);
    assign o_room2 = (r_count <= 3'(Depth - 2));
    assign o_head  = r_mem[r_rd_ptr];

    // a push never overruns the queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.count != 2'd0 |-> r_count + {1'b0, i_push.count} <= 3'(Depth) + {2'b00, pop})
        else $error("result queue overflow");

    // fill level stays within depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(Depth))
        else $error("result queue count out of range");

endmodule

[tb/tb.sv]
// self-checking testbench for the s-expression tokenizer: directed table, random streams
`timescale 1ns / 100ps

module tb;
    import stx_pkg::*;

    localparam int BUF_BYTES    = 256;
    localparam int SETTLE_CYC   = 8;
    localparam int HOLD_CYC     = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int PHASE_ITEMS  = 60;

    // one input beat plus any expectation typed in by hand (typed < 0: use the lexer model)
    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        int         typed;
        t_result    t0;
        t_result    t1;
    } t_stim;

    // one row of the directed table
    typedef struct {
        bit         is_cfg;
        logic [7:0] ch;
        logic       eoi;
        int         n;
        t_kind      k0;
        t_err       e0;
        t_kind      k1;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_ch_byte;
    logic        i_end_of_input;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [3:0]  o_kind;
    logic [7:0]  o_text_byte;
    logic [1:0]  o_error_code;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sexpr_tokenizer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_ch_byte      (i_ch_byte),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_text_byte    (o_text_byte),
        .o_error_code   (o_error_code),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #10 i_clk = ~i_clk;

    // lexer model state and configuration
    t_mode       m_mode;
    logic [8:0]  m_len;
    logic        m_esc;
    logic        m_digits;
    logic        m_sign;
    logic [7:0]  m_max_len;

    // results of the latest modeled byte
    t_result     step_res [2];
    int          step_cnt;

    t_result     pending_tokens [$];
    t_stim       stim_q [$];
    t_stim       cur_stim;
    t_row        dir_rows [$];
    int          fail_count;
    int          idle_cycles;
    bit          hold_req;
    bit          hold_done;

    wire in_beat  = i_in_valid && !o_in_stall;
    wire out_beat = o_out_valid && !i_out_stall;

    function automatic t_result tok(input t_kind k, input logic [7:0] b, input t_err e);
        t_result r;
        r.kind       = k;
        r.text_byte  = b;
        r.error_code = e;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic bit blank(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit decimal(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void emit(input t_kind k, input logic [7:0] b, input t_err e);
        step_res[step_cnt] = tok(k, b, e);
        step_cnt++;
    endfunction

    // append a body byte, or flag a too-long token and drop back to idle
    function automatic bit add_body(input logic [7:0] c);
        int lim;
        lim = (m_max_len < BUF_BYTES - 1) ? int'(m_max_len) : BUF_BYTES - 1;
        if (m_len >= lim) begin
            emit(KIND_ERR, 8'h00, ERR_TOO_LONG);
            m_mode = MODE_IDLE;
            return 1'b0;
        end
        m_len = m_len + 9'd1;
        emit(KIND_TEXT, c, ERR_NONE);
        return 1'b1;
    endfunction

    // classify a finished atom: a lone sign is a symbol
    function automatic void close_atom();
        logic num;
        num = m_digits && !(m_sign && m_len == 9'd1);
        emit(num ? KIND_NUM : KIND_SYM, 8'h00, ERR_NONE);
        m_mode = MODE_IDLE;
    endfunction

    function automatic void open_token(input t_mode md);
        m_mode   = md;
        m_len    = '0;
        m_esc    = 1'b0;
        m_digits = 1'b1;
        m_sign   = 1'b0;
    endfunction

    // lexer model: one byte or end of input, results left in step_res
    function automatic void lex_byte(input logic [7:0] c, input logic eoi);
        logic sign;
        step_cnt = 0;
        if (eoi) begin
            if (m_mode == MODE_STRING) emit(KIND_ERR, 8'h00, ERR_UNTERM);
            else if (m_mode == MODE_CHAR) emit(KIND_ERR, 8'h00, ERR_CHAR_EOF);
            else if (m_mode == MODE_ATOM) close_atom();
            emit(KIND_EOF, 8'h00, ERR_NONE);
            m_mode = MODE_IDLE;
        end else begin
            case (m_mode)
                MODE_COMMENT: begin
                    if (c == CH_LF) m_mode = MODE_IDLE;
                end
                MODE_STRING: begin
                    if (c == CH_DQUOTE && !m_esc) begin
                        emit(KIND_STR, 8'h00, ERR_NONE);
                        m_mode = MODE_IDLE;
                    end else if (add_body(c)) begin
                        m_esc = (c == CH_BSLASH) && !m_esc;
                    end
                end
                MODE_CHAR: begin
                    if (add_body(c)) begin
                        emit(KIND_CHAR, 8'h00, ERR_NONE);
                        m_mode = MODE_IDLE;
                    end
                end
                MODE_ATOM: begin
                    if (blank(c)) begin
                        close_atom();
                    end else if (c == CH_RPAR) begin
                        close_atom();
                        emit(KIND_RPAR, 8'h00, ERR_NONE);
                    end else if (add_body(c)) begin
                        m_digits = m_digits && decimal(c);
                    end
                end
                default: begin
                    m_mode = MODE_IDLE;
                    if (blank(c)) begin
                    end else if (c == CH_SEMI) begin
                        m_mode = MODE_COMMENT;
                    end else if (c == CH_LPAR) begin
                        emit(KIND_LPAR, 8'h00, ERR_NONE);
                    end else if (c == CH_RPAR) begin
                        emit(KIND_RPAR, 8'h00, ERR_NONE);
                    end else if (c == CH_QUOTE) begin
                        emit(KIND_QUOTE, 8'h00, ERR_NONE);
                    end else if (c == CH_DOT) begin
                        emit(KIND_DOT, 8'h00, ERR_NONE);
                    end else if (c == CH_DQUOTE) begin
                        open_token(MODE_STRING);
                    end else if (c == CH_BSLASH) begin
                        open_token(MODE_CHAR);
                    end else begin
                        sign = (c == CH_PLUS) || (c == CH_MINUS);
                        open_token(MODE_ATOM);
                        if (add_body(c)) begin
                            m_sign   = sign;
                            m_digits = sign || decimal(c);
                        end
                    end
                end
            endcase
        end
        if (step_cnt > 0) step_res[step_cnt - 1].last = 1'b1;
    endfunction

    function automatic void mismatch(input string what, input logic [7:0] want,
                                     input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        fail_count++;
    endfunction

    // monitor: compare output beats, model accepted input beats
    always @(posedge i_clk) begin : mon
        t_result want;
        if (i_rst_n) begin
            if (out_beat) begin
                if (pending_tokens.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d byte %0d",
                             $time, o_kind, o_text_byte);
                    fail_count++;
                end else begin
                    want = pending_tokens.pop_front();
                    if (o_kind !== want.kind) mismatch("kind", 8'(want.kind), 8'(o_kind));
                    if (o_text_byte !== want.text_byte)
                        mismatch("text_byte", want.text_byte, o_text_byte);
                    if (o_error_code !== want.error_code)
                        mismatch("error_code", 8'(want.error_code), 8'(o_error_code));
                    if (o_last !== want.last) mismatch("last", 8'(want.last), 8'(o_last));
                end
            end
            if (in_beat) begin
                lex_byte(i_ch_byte, i_end_of_input);
                if (cur_stim.typed < 0) begin
                    for (int k = 0; k < step_cnt; k++) pending_tokens.push_back(step_res[k]);
                end else begin
                    if (cur_stim.typed > 0) pending_tokens.push_back(cur_stim.t0);
                    if (cur_stim.typed > 1) pending_tokens.push_back(cur_stim.t1);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (in_beat || out_beat) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_tokens.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin : rx_stall
        int mode;
        int left;
        int hold;
        i_out_stall = 1'b0;
        mode = 0;
        left = 0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done && hold == 0) hold = HOLD_CYC;
            if (hold > 0) begin
                hold--;
                if (hold == 0) hold_done = 1'b1;
                i_out_stall <= 1'b1;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(10, 80);
                end
                left--;
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= ~i_out_stall;
                endcase
            end
        end
    end

    function automatic void push_byte(input logic [7:0] c);
        t_stim s;
        s.ch    = c;
        s.eoi   = 1'b0;
        s.typed = -1;
        stim_q.push_back(s);
    endfunction

    function automatic void push_eoi();
        t_stim s;
        s.ch    = 8'($urandom_range(0, 255));
        s.eoi   = 1'b1;
        s.typed = -1;
        stim_q.push_back(s);
    endfunction

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? 8'h20 : r[7:0];
    endfunction

    // first byte of an atom: anything the idle lexer does not treat specially
    function automatic logic [7:0] pick_atom_start();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (blank(c) || c == CH_SEMI || c == CH_LPAR || c == CH_RPAR || c == CH_QUOTE
               || c == CH_DOT || c == CH_DQUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] pick_atom_body();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (blank(c) || c == CH_RPAR);
        return c;
    endfunction

    // atom terminator: whitespace, close paren, or none at all
    function automatic void push_atom_end();
        case ($urandom_range(0, 3))
            0, 1: push_byte(pick_blank());
            2: push_byte(CH_RPAR);
            default: ;
        endcase
    endfunction

    // random stream: mostly well-formed tokens with random content, some noise
    function automatic void gen_stream(input int n_items);
        int base;
        int n;
        logic [7:0] c;
        base = stim_q.size();
        while (stim_q.size() - base < n_items) begin
            case ($urandom_range(0, 15))
                0, 1: begin
                    case ($urandom_range(0, 3))
                        0: push_byte(CH_LPAR);
                        1: push_byte(CH_RPAR);
                        2: push_byte(CH_DOT);
                        default: push_byte(CH_QUOTE);
                    endcase
                end
                2: push_byte(pick_blank());
                3: begin
                    push_byte(CH_SEMI);
                    n = $urandom_range(0, 6);
                    repeat (n) begin
                        do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
                        push_byte(c);
                    end
                    push_byte(CH_LF);
                end
                4, 5, 6: begin
                    push_byte(CH_DQUOTE);
                    n = $urandom_range(0, 8);
                    repeat (n) begin
                        case ($urandom_range(0, 7))
                            0: begin
                                push_byte(CH_BSLASH);
                                push_byte($urandom_range(0, 1) ? CH_DQUOTE : CH_BSLASH);
                            end
                            1: push_byte(CH_BSLASH);
                            default: begin
                                do c = 8'($urandom_range(0, 255)); while (c == CH_DQUOTE);
                                push_byte(c);
                            end
                        endcase
                    end
                    if ($urandom_range(0, 9) != 0) push_byte(CH_DQUOTE);
                end
                7: begin
                    push_byte(CH_BSLASH);
                    push_byte(8'($urandom_range(0, 255)));
                end
                8, 9: begin
                    case ($urandom_range(0, 2))
                        0: push_byte(CH_PLUS);
                        1: push_byte(CH_MINUS);
                        default: ;
                    endcase
                    n = $urandom_range(1, 5);
                    repeat (n) push_byte(8'($urandom_range(8'h30, 8'h39)));
                    push_atom_end();
                end
                10, 11: begin
                    push_byte(pick_atom_start());
                    n = $urandom_range(0, 6);
                    repeat (n) push_byte(pick_atom_body());
                    push_atom_end();
                end
                12: begin
                    push_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    push_atom_end();
                end
                13: push_eoi();
                default: push_byte(8'($urandom_range(0, 255)));
            endcase
        end
        push_eoi();
    endfunction

    // sender: bursts of beats with random gaps, or with no gaps when gapless is set
    task automatic send_all(input bit gapless);
        t_stim s;
        int burst;
        int gap;
        burst = 0;
        while (stim_q.size() > 0) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap > 0) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
            s = stim_q.pop_front();
            @(negedge i_clk);
            i_in_valid     <= 1'b1;
            i_ch_byte      <= s.ch;
            i_end_of_input <= s.eoi;
            cur_stim       <= s;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            burst--;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // wait for every expected result, then let the pipeline settle
    task automatic drain();
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // register write, then read back
    task automatic reg_write(input logic [7:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_TOKEN_LEN, 2'b00};
        pwdata  <= {24'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        m_max_len = val;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {24'd0, val}) begin
            $display("%0t: max_token_len readback, expected %0d, actual %0d",
                     $time, val, prdata);
            fail_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_row row(input bit is_cfg, input logic [7:0] ch, input logic eoi,
                                 input int n, input t_kind k0, input t_err e0,
                                 input t_kind k1);
        t_row r;
        r.is_cfg = is_cfg;
        r.ch     = ch;
        r.eoi    = eoi;
        r.n      = n;
        r.k0     = k0;
        r.e0     = e0;
        r.k1     = k1;
        return r;
    endfunction

    initial begin : main
        t_stim s;
        int    lim_plan [7];
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_ch_byte      = 8'h00;
        i_end_of_input = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        fail_count     = 0;
        hold_req       = 1'b0;
        m_max_len      = 8'd255;
        open_token(MODE_IDLE);
        cur_stim.typed = -1;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: typed rows give the result outright, -1 rows go through the model
        dir_rows.push_back(row(0, 8'h00,     1, 1, KIND_EOF,   ERR_NONE, KIND_EOF));
        dir_rows.push_back(row(0, CH_LPAR,   0, 1, KIND_LPAR,  ERR_NONE, KIND_EOF));
        dir_rows.push_back(row(0, CH_RPAR,   0, 1, KIND_RPAR,  ERR_NONE, KIND_EOF));
        dir_rows.push_back(row(0, CH_DOT,    0, 1, KIND_DOT,   ERR_NONE, KIND_EOF));
        dir_rows.push_back(row(0, CH_QUOTE,  0, 1, KIND_QUOTE, ERR_NONE, KIND_EOF));
        dir_rows.push_back(row(0, 8'h20,     0, 0, KIND_TEXT,  ERR_NONE, KIND_EOF));
        // comment swallows everything up to a line feed
        dir_rows.push_back(row(0, CH_SEMI,   0, 0, KIND_TEXT,  ERR_NONE, KIND_EOF));
        dir_rows.push_back(row(0, 8'hFF,     0, 0, KIND_TEXT,  ERR_NONE, KIND_EOF));
        dir_rows.push_back(row(0, CH_LF,     0, 0, KIND_TEXT,  ERR_NONE, KIND_EOF));
        // string with an escaped quote
        dir_rows.push_back(row(0, CH_DQUOTE, 0, 0, KIND_TEXT,  ERR_NONE, KIND_EOF));
        dir_rows.push_back(row(0, CH_BSLASH, 0, 1, KIND_TEXT,  ERR_NONE, KIND_EOF));
        dir_rows.push_back(row(0, CH_DQUOTE, 0, 1, KIND_TEXT,  ERR_NONE, KIND_EOF));
        dir_rows.push_back(row(0, CH_DQUOTE, 0, 1, KIND_STR,   ERR_NONE, KIND_EOF));
        // character literal
        dir_rows.push_back(row(0, CH_BSLASH, 0, 0, KIND_TEXT,  ERR_NONE, KIND_EOF));
        dir_rows.push_back(row(0, 8'hFF,     0, 2, KIND_TEXT,  ERR_NONE, KIND_CHAR));
        // lone sign ended by whitespace, signed number ended by close paren
        dir_rows.push_back(row(0, CH_MINUS,  0, 1, KIND_TEXT,  ERR_NONE, KIND_EOF));
        dir_rows.push_back(row(0, 8'h20,     0, -1, KIND_TEXT, ERR_NONE, KIND_TEXT));
        dir_rows.push_back(row(0, CH_PLUS,   0, -1, KIND_TEXT, ERR_NONE, KIND_TEXT));
        dir_rows.push_back(row(0, "7",       0, -1, KIND_TEXT, ERR_NONE, KIND_TEXT));
        dir_rows.push_back(row(0, CH_RPAR,   0, -1, KIND_TEXT, ERR_NONE, KIND_TEXT));
        // symbol holding delimiters, closed by end of input
        dir_rows.push_back(row(0, 8'h00,     0, -1, KIND_TEXT, ERR_NONE, KIND_TEXT));
        dir_rows.push_back(row(0, CH_LPAR,   0, -1, KIND_TEXT, ERR_NONE, KIND_TEXT));
        dir_rows.push_back(row(0, 8'h80,     0, -1, KIND_TEXT, ERR_NONE, KIND_TEXT));
        dir_rows.push_back(row(0, 8'h00,     1, -1, KIND_TEXT, ERR_NONE, KIND_TEXT));
        // end of input inside a string and after a lone backslash
        dir_rows.push_back(row(0, CH_DQUOTE, 0, 0, KIND_TEXT,  ERR_NONE, KIND_EOF));
        dir_rows.push_back(row(0, 8'hFF,     1, 2, KIND_ERR,   ERR_UNTERM, KIND_EOF));
        dir_rows.push_back(row(0, CH_BSLASH, 0, 0, KIND_TEXT,  ERR_NONE, KIND_EOF));
        dir_rows.push_back(row(0, 8'h00,     1, 2, KIND_ERR,   ERR_CHAR_EOF, KIND_EOF));
        // limit of one: second body byte is too long
        dir_rows.push_back(row(1, 8'd1,      0, 0, KIND_TEXT,  ERR_NONE, KIND_EOF));
        dir_rows.push_back(row(0, "a",       0, 1, KIND_TEXT,  ERR_NONE, KIND_EOF));
        dir_rows.push_back(row(0, "b",       0, 1, KIND_ERR,   ERR_TOO_LONG, KIND_EOF));
        dir_rows.push_back(row(0, "9",       0, -1, KIND_TEXT, ERR_NONE, KIND_TEXT));
        dir_rows.push_back(row(0, 8'h00,     1, -1, KIND_TEXT, ERR_NONE, KIND_TEXT));
        dir_rows.push_back(row(1, 8'd255,    0, 0, KIND_TEXT,  ERR_NONE, KIND_EOF));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                send_all(1'b0);
                drain();
                reg_write(dir_rows[i].ch);
            end else begin
                s.ch    = dir_rows[i].ch;
                s.eoi   = dir_rows[i].eoi;
                s.typed = dir_rows[i].n;
                s.t0 = tok(dir_rows[i].k0,
                           (dir_rows[i].k0 == KIND_TEXT) ? dir_rows[i].ch : 8'h00,
                           dir_rows[i].e0);
                s.t0.last = (dir_rows[i].n == 1);
                s.t1 = tok(dir_rows[i].k1, 8'h00, ERR_NONE);
                s.t1.last = 1'b1;
                stim_q.push_back(s);
            end
        end
        send_all(1'b0);
        drain();

        // random phases over a spread of limits, the last one under output pressure
        lim_plan[0] = 255;
        lim_plan[1] = 1;
        lim_plan[2] = 2;
        lim_plan[3] = $urandom_range(3, 16);
        lim_plan[4] = 254;
        lim_plan[5] = $urandom_range(1, 255);
        lim_plan[6] = 255;
        foreach (lim_plan[p]) begin
            reg_write(8'(lim_plan[p]));
            if (p == 0) begin
                // longest token: an atom that fills the limit, then one byte over it
                repeat (256) push_byte("z");
                push_byte(8'h20);
            end
            gen_stream(PHASE_ITEMS);
            if (p == 6) hold_req = 1'b1;
            send_all(p == 6);
            drain();
        end

        while (hold_req && !hold_done) @(posedge i_clk);
        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
